// ===== rtl/core/xcpr_pkg.sv =====
// ----------------------------------------------------------------------------
// xcpr_pkg
// Shared sizes, codes and types of the packet ring receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package xcpr_pkg;

    localparam int BLOCK_BYTES = 8;
    localparam int BLOCK_SLOTS = 4;
    localparam int MAX_OUT     = 8;

    localparam int BYTE_W     = 8;
    localparam int PLEN_W     = 3;
    localparam int GAP_W      = 16;
    localparam int EV_W       = 4;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int SLOT_W = $clog2(BLOCK_SLOTS);
    localparam int USED_W = $clog2(BLOCK_SLOTS + 1);
    localparam int ADDR_W = $clog2(BLOCK_BYTES * BLOCK_SLOTS);
    localparam int CNT_W  = $clog2(MAX_OUT + 1);

    localparam int DATA_MAX_INT = (BLOCK_BYTES - 1 < 7) ? BLOCK_BYTES - 1 : 7;
    localparam logic [PLEN_W-1:0] DATA_MAX = PLEN_W'(DATA_MAX_INT);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GAP    = CFG_IDX_W'(2);

    localparam logic [BYTE_W-1:0] HEADER_RST = BYTE_W'(0);
    localparam logic [PLEN_W-1:0] PLEN_RST   = PLEN_W'(1);
    localparam logic [GAP_W-1:0]  GAP_RST    = GAP_W'(100);

    typedef enum logic [CMD_W-1:0] {
        CMD_BYTE = 2'd0,
        CMD_TICK = 2'd1,
        CMD_POP  = 2'd2
    } cmd_t;

    typedef enum logic [EV_W-1:0] {
        EV_TAKEN      = 4'd0,
        EV_IGNORED    = 4'd1,
        EV_COMMIT     = 4'd2,
        EV_BAD_SUM    = 4'd3,
        EV_FULL_DROP  = 4'd4,
        EV_TICK       = 4'd5,
        EV_TIMEOUT    = 4'd6,
        EV_BLOCK_BYTE = 4'd7,
        EV_EMPTY      = 4'd8
    } event_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic                is_pop;
        event_t              ev;
        logic                ring_empty;
        logic [SLOT_W-1:0]   slot;
        logic [CNT_W-1:0]    len;
    } queue_entry_t;

    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]   data;
    } store_wr_t;

    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
    } store_rd_t;

    function automatic logic [ADDR_W-1:0] block_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [CNT_W-1:0]  idx);
        return ADDR_W'(slot) * ADDR_W'(BLOCK_BYTES) + ADDR_W'(idx);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/xcpr_channels.sv =====
// ----------------------------------------------------------------------------
// xcpr channels
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface xcpr_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;

    modport source (output valid, cmd, data_byte, input ready);
    modport sink   (input valid, cmd, data_byte, output ready);
endinterface

interface xcpr_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_res;
    logic [7:0] block_data;
    logic       last;
    logic       ring_empty;

    modport source (output valid, event_res, block_data, last, ring_empty, input ready);
    modport sink   (input valid, event_res, block_data, last, ring_empty, output ready);
endinterface

interface xcpr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/xcpr_store.sv =====
// ----------------------------------------------------------------------------
// xcpr_store
// Block store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module xcpr_store
    import xcpr_pkg::*;
(
    input  wire logic              clk,
    input  wire store_wr_t         wr,
    input  wire store_rd_t         rd,
    output logic [BYTE_W-1:0]      rd_data
);

    logic [BYTE_W-1:0] mem_reg [BLOCK_BYTES*BLOCK_SLOTS];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem_reg[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/xcpr_queue.sv =====
// ----------------------------------------------------------------------------
// xcpr_queue
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module xcpr_queue
    import xcpr_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire queue_entry_t  entry_in,
    input  wire logic          pop,
    output queue_entry_t       entry_out,
    output logic               not_empty,
    output logic               full
);

    queue_entry_t        entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= entry_in;
        end
    end

    assign entry_out = entries_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

// ===== rtl/core/xcpr_front.sv =====
// ----------------------------------------------------------------------------
// xcpr_front
// Front part: registers, packet framing, gap timer and ring bookkeeping.
// ----------------------------------------------------------------------------
`default_nettype none

module xcpr_front
    import xcpr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    xcpr_item_if.sink     item,
    xcpr_cfg_if.sink      cfg,
    output store_wr_t     store_wr,
    output queue_entry_t  q_entry,
    output logic          q_push,
    input  wire logic     q_full,
    input  wire logic     pop_done
);

    logic [BYTE_W-1:0] header_reg;
    logic [PLEN_W-1:0] plen_reg;
    logic [GAP_W-1:0]  gap_reg;

    logic              receiving_reg, receiving_next;
    logic [CNT_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [CNT_W-1:0]  write_index_reg, write_index_next;
    logic [GAP_W-1:0]  timer_reg, timer_next;
    logic [SLOT_W-1:0] in_slot_reg, in_slot_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic              overflow_reg, overflow_next;
    logic              pop_busy_reg, pop_busy_next;

    logic              accept;
    logic [PLEN_W-1:0] data_len;
    logic [CNT_W-1:0]  pkt_bytes;
    logic [CNT_W-1:0]  bytes_dec;
    logic              ring_full;
    event_t            ev;
    logic              is_pop;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(BLOCK_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    assign item.ready = !q_full && !pop_busy_reg;
    assign cfg.ready  = 1'b1;
    assign accept     = item.valid && item.ready;

    assign data_len  = (plen_reg > DATA_MAX) ? DATA_MAX : plen_reg;
    assign pkt_bytes = CNT_W'(data_len) + CNT_W'(1);
    assign bytes_dec = (bytes_left_reg != '0) ? bytes_left_reg - CNT_W'(1) : bytes_left_reg;
    assign ring_full = (used_reg == USED_W'(BLOCK_SLOTS));

    always_comb
    begin
        receiving_next   = receiving_reg;
        bytes_left_next  = bytes_left_reg;
        xor_next         = xor_reg;
        write_index_next = write_index_reg;
        timer_next       = timer_reg;
        in_slot_next     = in_slot_reg;
        out_slot_next    = out_slot_reg;
        used_next        = used_reg;
        overflow_next    = overflow_reg;
        pop_busy_next    = pop_done ? 1'b0 : pop_busy_reg;
        ev               = EV_IGNORED;
        is_pop           = 1'b0;
        store_wr.en      = 1'b0;
        store_wr.addr    = block_addr(in_slot_reg, write_index_reg);
        store_wr.data    = item.data_byte;

        if (accept)
        begin
            case (cmd_t'(item.cmd))
                CMD_BYTE:
                begin
                    if (!receiving_reg)
                    begin
                        if (item.data_byte == header_reg)
                        begin
                            bytes_left_next  = pkt_bytes;
                            overflow_next    = ring_full;
                            store_wr.en      = !ring_full;
                            store_wr.addr    = block_addr(in_slot_reg, '0);
                            write_index_next = CNT_W'(1);
                            timer_next       = gap_reg;
                            xor_next         = item.data_byte;
                            receiving_next   = 1'b1;
                            ev               = EV_TAKEN;
                        end
                    end
                    else
                    begin
                        bytes_left_next = bytes_dec;
                        if (bytes_dec != '0)
                        begin
                            store_wr.en      = !ring_full;
                            overflow_next    = overflow_reg || ring_full;
                            write_index_next = write_index_reg + CNT_W'(1);
                            timer_next       = gap_reg;
                            xor_next         = xor_reg ^ item.data_byte;
                            ev               = EV_TAKEN;
                        end
                        else
                        begin
                            if (xor_reg != item.data_byte)
                            begin
                                ev = EV_BAD_SUM;
                            end
                            else if (overflow_reg || ring_full)
                            begin
                                ev = EV_FULL_DROP;
                            end
                            else
                            begin
                                in_slot_next = slot_inc(in_slot_reg);
                                used_next    = used_reg + USED_W'(1);
                                ev           = EV_COMMIT;
                            end
                            write_index_next = '0;
                            timer_next       = '0;
                            receiving_next   = 1'b0;
                            overflow_next    = 1'b0;
                        end
                    end
                end
                CMD_TICK:
                begin
                    ev = EV_TICK;
                    if (timer_reg != '0)
                    begin
                        timer_next = timer_reg - GAP_W'(1);
                        if (timer_reg == GAP_W'(1))
                        begin
                            if (receiving_reg)
                            begin
                                ev = EV_TIMEOUT;
                            end
                            receiving_next   = 1'b0;
                            bytes_left_next  = '0;
                            write_index_next = '0;
                            overflow_next    = 1'b0;
                        end
                    end
                end
                CMD_POP:
                begin
                    if (used_reg == '0)
                    begin
                        ev = EV_EMPTY;
                    end
                    else
                    begin
                        is_pop        = 1'b1;
                        ev            = EV_BLOCK_BYTE;
                        out_slot_next = slot_inc(out_slot_reg);
                        used_next     = used_reg - USED_W'(1);
                        pop_busy_next = 1'b1;
                    end
                end
                default:
                begin
                    ev = EV_IGNORED;
                end
            endcase
        end
    end

    assign q_push             = accept;
    assign q_entry.is_pop     = is_pop;
    assign q_entry.ev         = ev;
    assign q_entry.ring_empty = (used_next == '0);
    assign q_entry.slot       = out_slot_reg;
    assign q_entry.len        = pkt_bytes;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RST;
            plen_reg   <= PLEN_RST;
            gap_reg    <= GAP_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_HEADER: header_reg <= cfg.data[BYTE_W-1:0];
                CFG_LENGTH: plen_reg   <= cfg.data[PLEN_W-1:0];
                CFG_GAP:    gap_reg    <= cfg.data[GAP_W-1:0];
                default:    header_reg <= header_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg   <= 1'b0;
            bytes_left_reg  <= '0;
            xor_reg         <= '0;
            write_index_reg <= '0;
            timer_reg       <= '0;
            in_slot_reg     <= '0;
            out_slot_reg    <= '0;
            used_reg        <= '0;
            overflow_reg    <= 1'b0;
            pop_busy_reg    <= 1'b0;
        end
        else
        begin
            receiving_reg   <= receiving_next;
            bytes_left_reg  <= bytes_left_next;
            xor_reg         <= xor_next;
            write_index_reg <= write_index_next;
            timer_reg       <= timer_next;
            in_slot_reg     <= in_slot_next;
            out_slot_reg    <= out_slot_next;
            used_reg        <= used_next;
            overflow_reg    <= overflow_next;
            pop_busy_reg    <= pop_busy_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/xcpr_back.sv =====
// ----------------------------------------------------------------------------
// xcpr_back
// Back part: turns queued items into results and streams popped blocks.
// ----------------------------------------------------------------------------
`default_nettype none

module xcpr_back
    import xcpr_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire queue_entry_t   q_entry,
    input  wire logic           q_valid,
    output logic                q_pop,
    output store_rd_t           store_rd,
    input  wire logic [BYTE_W-1:0] rd_data,
    output logic                pop_done,
    xcpr_result_if.source       result
);

    back_state_t        state_reg, state_next;
    logic [SLOT_W-1:0]  slot_reg;
    logic [CNT_W-1:0]   len_reg;
    logic               empty_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               out_valid_reg;
    event_t             out_ev_reg;
    logic [BYTE_W-1:0]  out_data_reg;
    logic               out_last_reg;
    logic               out_empty_reg;

    logic               out_free;
    logic               last_byte;
    logic               latch;
    logic               load;
    event_t             ld_ev;
    logic [BYTE_W-1:0]  ld_data;
    logic               ld_last;
    logic               ld_empty;

    assign out_free  = !out_valid_reg || result.ready;
    assign last_byte = (cnt_reg == len_reg - CNT_W'(1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && q_entry.is_pop)
                begin
                    state_next = BK_FETCH;
                end
            end
            BK_FETCH:
            begin
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last_byte ? BK_IDLE : BK_FETCH;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop         = 1'b0;
        latch         = 1'b0;
        load          = 1'b0;
        pop_done      = 1'b0;
        cnt_next      = cnt_reg;
        store_rd.en   = 1'b0;
        store_rd.addr = block_addr(slot_reg, cnt_reg);
        ld_ev         = q_entry.ev;
        ld_data       = '0;
        ld_last       = 1'b1;
        ld_empty      = q_entry.ring_empty;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_entry.is_pop)
                    begin
                        q_pop    = 1'b1;
                        latch    = 1'b1;
                        cnt_next = '0;
                    end
                    else if (out_free)
                    begin
                        q_pop = 1'b1;
                        load  = 1'b1;
                    end
                end
            end
            BK_FETCH:
            begin
                store_rd.en = 1'b1;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    load     = 1'b1;
                    ld_ev    = EV_BLOCK_BYTE;
                    ld_data  = rd_data;
                    ld_last  = last_byte;
                    ld_empty = empty_reg;
                    if (last_byte)
                    begin
                        pop_done = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (latch)
        begin
            slot_reg  <= q_entry.slot;
            len_reg   <= q_entry.len;
            empty_reg <= q_entry.ring_empty;
        end
        if (load)
        begin
            out_ev_reg    <= ld_ev;
            out_data_reg  <= ld_data;
            out_last_reg  <= ld_last;
            out_empty_reg <= ld_empty;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.event_res  = out_ev_reg;
    assign result.block_data = out_data_reg;
    assign result.last       = out_last_reg;
    assign result.ring_empty = out_empty_reg;

endmodule

`default_nettype wire

// ===== rtl/core/xor_checked_packet_ring_receiver_core.sv =====
// ----------------------------------------------------------------------------
// xor_checked_packet_ring_receiver_core
// Frames XOR-checked packets from a byte stream into a ring of blocks.
// ----------------------------------------------------------------------------
//  channel  | dir | fields                                      | accepted when
//  item     | in  | cmd[1:0], data_byte[7:0]                    | valid & ready
//  result   | out | event_res[3:0], block_data[7:0], last, ring_empty | valid & ready
//  cfg      | in  | index[1:0], data[15:0]                      | valid & ready
//
//  Byte, tick and other items: one per cycle while ready (queue not full,
//  not popping); result via queue, then output register. A pop gives header
//  plus data bytes, each via block store read, then output register; intake
//  holds from the pop until its last byte is loaded. Reset clears all control
//  state at once; the block store holds no reset value and needs no clearing
//  pass. A stalled result holds in the output register while the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_checked_packet_ring_receiver_core
    import xcpr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    xcpr_item_if.sink      item,
    xcpr_result_if.source  result,
    xcpr_cfg_if.sink       cfg
);

    store_wr_t          store_wr;
    store_rd_t          store_rd;
    logic [BYTE_W-1:0]  rd_data;
    queue_entry_t       q_in;
    queue_entry_t       q_out;
    logic               q_push;
    logic               q_pop;
    logic               q_valid;
    logic               q_full;
    logic               pop_done;

    xcpr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cfg      (cfg),
        .store_wr (store_wr),
        .q_entry  (q_in),
        .q_push   (q_push),
        .q_full   (q_full),
        .pop_done (pop_done)
    );

    xcpr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .entry_in  (q_in),
        .pop       (q_pop),
        .entry_out (q_out),
        .not_empty (q_valid),
        .full      (q_full)
    );

    xcpr_store u_store (
        .clk     (clk),
        .wr      (store_wr),
        .rd      (store_rd),
        .rd_data (rd_data)
    );

    xcpr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_entry  (q_out),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .store_rd (store_rd),
        .rd_data  (rd_data),
        .pop_done (pop_done),
        .result   (result)
    );

endmodule

`default_nettype wire
